@@ sv/srtm_pkg.sv @@
// package for the send/receive tag matching queues
// holds the result status codes and the controller/datapath command and status types
// no dependencies
`default_nettype none

package srtm_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_MATCHED = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned ENTRY_W = KEY_W + VALUE_W;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load;      // capture request, clear index
    logic    rd_cur;    // read entry at index of the searched queue
    logic    rd_next;   // read entry at index + 1 of the searched queue
    logic    wr_cur;    // write read data at index, advance index
    logic    idx_inc;   // advance index
    logic    append;    // store request as youngest entry of the other queue
    logic    dec;       // one entry fewer in the searched queue
    logic    set_res;   // latch a result
    status_e res;       // status to latch
    logic    push;      // move latched result into the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic at_end;     // index reached the searched queue fill count
    logic last;       // index + 1 equals the searched queue fill count
    logic hit;        // read key equals request key
    logic full;       // other queue holds its full depth
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/srtm_if.sv @@
// request and result channel interfaces for the tag matching queues
// depends on srtm_pkg
`default_nettype none

interface srtm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [srtm_pkg::KEY_W-1:0]   match_key;
  logic [srtm_pkg::VALUE_W-1:0] payload;

  modport source (output valid, output mode, output match_key, output payload, input ready);
  modport sink   (input valid, input mode, input match_key, input payload, output ready);
endinterface

interface srtm_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [srtm_pkg::VALUE_W-1:0] matched_value;

  modport source (output valid, output status, output matched_value, input ready);
  modport sink   (input valid, input status, input matched_value, output ready);
endinterface

`default_nettype wire

@@ sv/srtm_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module srtm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/srtm_ctrl.sv @@
// controller state machine for the tag matching queues
// sequences search, compaction and append; depends on srtm_pkg
`default_nettype none

module srtm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire srtm_pkg::dp_stat_t  stat_i,
  output srtm_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_MV,
    S_MVCHK,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    cmd_o   = '0;
    cmd_o.res = srtm_pkg::ST_MATCHED;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        if (stat_i.at_end) begin
          // miss: append to the other queue unless it is full
          cmd_o.set_res = 1'b1;
          if (stat_i.full) begin
            cmd_o.res = srtm_pkg::ST_FULL;
          end else begin
            cmd_o.res    = srtm_pkg::ST_QUEUED;
            cmd_o.append = 1'b1;
          end
          state_d = S_FIN;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = srtm_pkg::ST_MATCHED;
          if (stat_i.last) begin
            cmd_o.dec = 1'b1;
            state_d   = S_FIN;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_MV;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_MV: begin
        // move younger entry up one place
        cmd_o.wr_cur = 1'b1;
        state_d      = S_MVCHK;
      end
      S_MVCHK: begin
        if (stat_i.last) begin
          cmd_o.dec = 1'b1;
          state_d   = S_FIN;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_MV;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/srtm_dp.sv @@
// datapath for the tag matching queues: entry ram, fill counts, index, result registers
// depends on srtm_pkg and srtm_ram
`default_nettype none

module srtm_dp #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srtm_pkg::ctrl_cmd_t           cmd_i,
  output srtm_pkg::dp_stat_t                 stat_o,
  input  wire logic                          in_mode_i,
  input  wire logic [srtm_pkg::KEY_W-1:0]    in_key_i,
  input  wire logic [srtm_pkg::VALUE_W-1:0]  in_payload_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         out_status_o,
  output logic [srtm_pkg::VALUE_W-1:0]       out_value_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = IW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic                          mode_q;
  logic [srtm_pkg::KEY_W-1:0]    key_q;
  logic [srtm_pkg::VALUE_W-1:0]  payload_q;
  logic [CW-1:0]                 idx_q, cnt_a_q, cnt_b_q;
  logic [CW-1:0]                 cnt_search, cnt_store;
  logic [srtm_pkg::ENTRY_W-1:0]  rdata, wdata;
  logic [AW-1:0]                 waddr, raddr;
  logic [IW-1:0]                 idx_lo, idx_nx;
  logic                          we;
  srtm_pkg::status_e             rs_status_q;
  logic [srtm_pkg::VALUE_W-1:0]  rs_value_q;
  logic                          ov_q;
  logic [1:0]                    ostatus_q;
  logic [srtm_pkg::VALUE_W-1:0]  ovalue_q;

  assign cnt_search = mode_q ? cnt_b_q : cnt_a_q;
  assign cnt_store  = mode_q ? cnt_a_q : cnt_b_q;
  assign idx_lo     = idx_q[IW-1:0];
  assign idx_nx     = idx_lo + 1'b1;

  // ram addressing: queue select on top, entry index below
  assign we    = cmd_i.wr_cur | cmd_i.append;
  assign waddr = cmd_i.append ? {~mode_q, cnt_store[IW-1:0]} : {mode_q, idx_lo};
  assign wdata = cmd_i.append ? {key_q, payload_q} : rdata;
  assign raddr = cmd_i.rd_next ? {mode_q, idx_nx} : {mode_q, idx_lo};

  srtm_ram #(
    .WIDTH (srtm_pkg::ENTRY_W),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status toward the controller
  assign stat_o.at_end   = (idx_q == cnt_search);
  assign stat_o.last     = (CW'(idx_q + 1'b1) == cnt_search);
  assign stat_o.hit      = (rdata[srtm_pkg::ENTRY_W-1:srtm_pkg::VALUE_W] == key_q);
  assign stat_o.full     = (cnt_store == DEPTH_C);
  assign stat_o.out_free = !ov_q || out_ready_i;

  // request capture and result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= in_mode_i;
      key_q     <= in_key_i;
      payload_q <= in_payload_i;
    end
    if (cmd_i.set_res) begin
      rs_status_q <= cmd_i.res;
      rs_value_q  <= (cmd_i.res == srtm_pkg::ST_MATCHED) ?
                     rdata[srtm_pkg::VALUE_W-1:0] : '0;
    end
    if (cmd_i.push) begin
      ostatus_q <= rs_status_q;
      ovalue_q  <= rs_value_q;
    end
  end

  // index, fill counts and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc || cmd_i.wr_cur) begin
        idx_q <= CW'(idx_q + 1'b1);
      end
      if (cmd_i.append) begin
        if (mode_q) cnt_b_q <= cnt_b_q; else cnt_b_q <= CW'(cnt_b_q + 1'b1);
        if (mode_q) cnt_a_q <= CW'(cnt_a_q + 1'b1);
      end
      if (cmd_i.dec) begin
        if (mode_q) cnt_b_q <= CW'(cnt_b_q - 1'b1); else cnt_a_q <= CW'(cnt_a_q - 1'b1);
      end
      if (cmd_i.push) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ostatus_q;
  assign out_value_o  = ovalue_q;

endmodule

`default_nettype wire

@@ sv/send_recv_tag_match_queues_unit.sv @@
// Two-sided tag matching queues (posted / unexpected matching).
// Request channel in_i carries mode, match_key and payload; result channel
// out_o carries status and matched_value, both valid/ready.
// mode 0 searches queue A for its oldest equal key, mode 1 searches queue B.
// A hit removes that entry (younger entries move up) and returns its value
// with status matched; a miss appends the request to the other queue (status
// queued) or, when that queue is full, drops it (status full).
// Entries of both queues sit in one ram with one read and one write port,
// so one request is worked at a time: a search reads and compares each entry
// examined in turn, and a removal then moves each younger entry up by one
// read and one write; the ram port sets this pace.
// Reset empties both queues at once (fill counts cleared) and drops any
// pending result. The result sits in an output register; while the receiver
// stalls, the next request is still taken and worked, and it waits only to
// hand over its own result.
// depends on srtm_pkg, srtm_if, srtm_ctrl, srtm_dp
`default_nettype none

module send_recv_tag_match_queues_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srtm_in_if.sink   in_i,
  srtm_out_if.source out_o
);

  srtm_pkg::ctrl_cmd_t cmd;
  srtm_pkg::dp_stat_t  stat;
  logic                in_ready;

  srtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  srtm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_mode_i    (in_i.mode),
    .in_key_i     (in_i.match_key),
    .in_payload_i (in_i.payload),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_value_o  (out_o.matched_value)
  );

  assign in_i.ready = in_ready;

  // one request in flight: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while one is in flight");

  // value is zero unless matched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != srtm_pkg::ST_MATCHED) |-> (out_o.matched_value == '0))
    else $error("nonzero value on unmatched result");

  // a new result is only pushed after the request was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result appeared without a request in flight");

endmodule

`default_nettype wire

@@ sim/srtm_tb_checker.sv @@
// checker for the tag matching queues: watches both channels, predicts results
// from its own model of the two age-ordered queues and compares them in order
// depends on srtm_pkg and srtm_if
`timescale 1ns / 1ps
`default_nettype none

module srtm_tb_checker #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srtm_in_if.sink   req_mon,
  srtm_out_if.sink  res_mon,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct {
    srtm_pkg::status_e            status;
    logic [srtm_pkg::VALUE_W-1:0] value;
  } match_result_t;

  // model queues, oldest entry at index 0
  logic [srtm_pkg::KEY_W-1:0]   a_keys[$];
  logic [srtm_pkg::VALUE_W-1:0] a_vals[$];
  logic [srtm_pkg::KEY_W-1:0]   b_keys[$];
  logic [srtm_pkg::VALUE_W-1:0] b_vals[$];
  match_result_t                expected_results[$];

  assign pending_o = expected_results.size();

  // works out the result of one request and updates the model queues
  function automatic match_result_t match_request(logic mode,
                                                  logic [srtm_pkg::KEY_W-1:0] key,
                                                  logic [srtm_pkg::VALUE_W-1:0] val);
    match_result_t r;
    r.status = srtm_pkg::ST_FULL;
    r.value  = '0;
    if (mode == 1'b0) begin
      foreach (a_keys[i]) begin
        if (a_keys[i] == key) begin
          r.status = srtm_pkg::ST_MATCHED;
          r.value  = a_vals[i];
          a_keys.delete(i);
          a_vals.delete(i);
          return r;
        end
      end
      if (b_keys.size() < DEPTH) begin
        b_keys.push_back(key);
        b_vals.push_back(val);
        r.status = srtm_pkg::ST_QUEUED;
      end
    end else begin
      foreach (b_keys[i]) begin
        if (b_keys[i] == key) begin
          r.status = srtm_pkg::ST_MATCHED;
          r.value  = b_vals[i];
          b_keys.delete(i);
          b_vals.delete(i);
          return r;
        end
      end
      if (a_keys.size() < DEPTH) begin
        a_keys.push_back(key);
        a_vals.push_back(val);
        r.status = srtm_pkg::ST_QUEUED;
      end
    end
    return r;
  endfunction

  // predict on each accepted request, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    match_result_t exp_r;
    int            errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(match_request(req_mon.mode, req_mon.match_key,
                                                 req_mon.payload));
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending: status %0d", res_mon.status);
          errs = errs + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_mon.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, res_mon.status);
            errs = errs + 1;
          end
          if (res_mon.matched_value !== exp_r.value) begin
            $error("matched_value: expected %h, actual %h", exp_r.value,
                   res_mon.matched_value);
            errs = errs + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

`default_nettype wire

@@ sim/send_recv_tag_match_queues_unit_tb.sv @@
// testbench top for send_recv_tag_match_queues_unit: drives requests with
// random gaps and result stalls, the checker predicts and compares
// depends on srtm_pkg, srtm_if, srtm_tb_checker and the block
`timescale 1ns / 1ps
`default_nettype none

module send_recv_tag_match_queues_unit_tb;

  localparam int unsigned DEPTH = 32;
  localparam int          NUM_RANDOM = 1500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  bit   stim_done = 1'b0;
  bit   long_stall = 1'b0;

  srtm_in_if  req_ch();
  srtm_out_if res_ch();

  send_recv_tag_match_queues_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (res_ch.source)
  );

  srtm_tb_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch.sink),
    .res_mon     (res_ch.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  // small key pool so that matches happen often
  function automatic logic [srtm_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return {$urandom, $urandom};
      1:       return '1;
      2:       return '0;
      default: return 64'hA5A5_0000_0000_0000 | 64'($urandom_range(0, 11));
    endcase
  endfunction

  function automatic logic [srtm_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offers one request after a random gap and waits for its acceptance
  task automatic send_request(logic mode, logic [srtm_pkg::KEY_W-1:0] key,
                              logic [srtm_pkg::VALUE_W-1:0] val);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.match_key <= key;
    req_ch.payload   <= val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_stall = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk_i);
        while (!res_ch.valid) @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    logic [srtm_pkg::KEY_W-1:0] key;
    req_ch.valid     = 1'b0;
    req_ch.mode      = 1'b0;
    req_ch.match_key = '0;
    req_ch.payload   = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, all-ones key/value, duplicates, both directions
    send_request(1'b0, '1, '1);
    send_request(1'b1, '1, 64'h1);
    send_request(1'b1, '0, '0);
    send_request(1'b1, 64'h77, 64'h100);
    send_request(1'b1, 64'h77, 64'h200);
    send_request(1'b0, 64'h77, 64'h0);
    send_request(1'b0, 64'h77, 64'h0);
    send_request(1'b0, 64'h77, 64'h0);
    send_request(1'b0, '0, '1);
    send_request(1'b1, '0, 64'h5);
    send_request(1'b0, '1, '0);
    // fill queue B to full and beyond, then drain part of it
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(1'b0, 64'h1000 + 64'(i), {$urandom, $urandom});
    send_request(1'b1, 64'h1000 + 64'(DEPTH) - 64'd1, '0);
    send_request(1'b1, 64'h1000, '0);

    // random part with one long receiver hold-off while requests go on
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) long_stall = 1'b1;
      key = pick_key();
      send_request(1'($urandom_range(0, 1)), key, pick_value());
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (4 * DEPTH + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // timeout
  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

@@ send_recv_tag_match_queues_unit.f @@
sv/srtm_pkg.sv
sv/srtm_if.sv
sv/srtm_ram.sv
sv/srtm_ctrl.sv
sv/srtm_dp.sv
sv/send_recv_tag_match_queues_unit.sv
sim/srtm_tb_checker.sv
sim/send_recv_tag_match_queues_unit_tb.sv
